/* rtl/core/sle_pkg.sv */
package sle_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic [ADDR_W-1:0]             t_addr;
    typedef logic [CNT_W-1:0]              t_cnt;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_REM_FIRST = 3'd1,
        CMD_REM_LAST  = 3'd2,
        CMD_REM_AT    = 3'd3,
        CMD_SEARCH    = 3'd4,
        CMD_CLEAR     = 3'd5
    } t_cmd;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_val  wdata;
        t_addr raddr;
    } t_ram_req;

endpackage

/* rtl/core/sorted_list_engine_unit.sv */
// Channel | Direction | Handshake          | Payload
// command | in        | i_valid / o_stall  | i_command, i_value, i_position
// result  | out       | o_valid / i_stall  | o_ok, o_found_position, o_count
//
// A command is taken only while the sequencer is idle; o_stall is high otherwise.
// Insert moves each of the entries not less than the value up one place, from the back,
// and writes the value in the slot so freed, which may be the front of the list.
// Remove moves the entries behind the removed one down one place; search scans from the
// front of the list and stops at the first match, or at the end of the list for none.
// Every step is bound by the single read port of the entry memory and its registered read data.
// Reset empties the list; a held result stalls only the completion of the next command.
module sorted_list_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [6:0]  o_found_position,
    output logic [6:0]  o_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_REM_RD, S_REM_WR, S_SRCH_RD, S_SRCH_CMP, S_PUT
    } t_state;

    t_state            r_state;
    sle_pkg::t_cnt     r_count;
    sle_pkg::t_cnt     r_idx;
    sle_pkg::t_val     r_val;
    logic              r_res_ok;
    sle_pkg::t_cnt     r_res_found;
    logic              r_ovalid;
    logic              r_ok;
    logic [6:0]        r_found;
    logic [6:0]        r_cnt_out;
    sle_pkg::t_ram_req n_req;
    sle_pkg::t_val     w_rdata;
    sle_pkg::t_cnt     w_idx_m1;
    sle_pkg::t_cnt     w_idx_p1;
    sle_pkg::t_cnt     w_pos;

    assign w_idx_m1 = r_idx - 1'b1;
    assign w_idx_p1 = r_idx + 1'b1;
    assign w_pos    = sle_pkg::CNT_W'(i_position);

    sle_ram #(
        .DEPTH(sle_pkg::CAPACITY),
        .WIDTH(sle_pkg::VALUE_WIDTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (n_req.we),
        .i_waddr(n_req.waddr),
        .i_wdata(n_req.wdata),
        .i_raddr(n_req.raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_req.we    = 1'b0;
        n_req.waddr = r_idx[sle_pkg::ADDR_W-1:0];
        n_req.wdata = r_val;
        n_req.raddr = r_idx[sle_pkg::ADDR_W-1:0];
        unique case (r_state)
            S_INS_RD: begin
                n_req.raddr = w_idx_m1[sle_pkg::ADDR_W-1:0];
                n_req.we    = (r_idx == '0);
            end
            S_INS_CMP: begin
                n_req.we    = 1'b1;
                n_req.wdata = (w_rdata >= r_val) ? w_rdata : r_val;
            end
            S_REM_RD: begin
                n_req.raddr = w_idx_p1[sle_pkg::ADDR_W-1:0];
            end
            S_REM_WR: begin
                n_req.we    = 1'b1;
                n_req.wdata = w_rdata;
            end
            S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_PUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != S_PUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_val       <= i_value[sle_pkg::VALUE_WIDTH-1:0];
                        r_res_ok    <= 1'b0;
                        r_res_found <= '0;
                        r_state     <= S_PUT;
                        case (sle_pkg::t_cmd'(i_command))
                            sle_pkg::CMD_INSERT: begin
                                if (r_count < sle_pkg::CNT_W'(sle_pkg::CAPACITY)) begin
                                    r_idx   <= r_count;
                                    r_state <= S_INS_RD;
                                end
                            end
                            sle_pkg::CMD_REM_FIRST: begin
                                if (r_count != '0) begin
                                    r_idx    <= '0;
                                    r_res_ok <= 1'b1;
                                    r_state  <= S_REM_RD;
                                end
                            end
                            sle_pkg::CMD_REM_LAST: begin
                                if (r_count != '0) begin
                                    r_count  <= r_count - 1'b1;
                                    r_res_ok <= 1'b1;
                                end
                            end
                            sle_pkg::CMD_REM_AT: begin
                                if (i_position != '0 && w_pos <= r_count) begin
                                    r_idx    <= w_pos - 1'b1;
                                    r_res_ok <= 1'b1;
                                    r_state  <= S_REM_RD;
                                end
                            end
                            sle_pkg::CMD_SEARCH: begin
                                r_idx    <= '0;
                                r_res_ok <= 1'b1;
                                r_state  <= S_SRCH_RD;
                            end
                            sle_pkg::CMD_CLEAR: begin
                                r_count  <= '0;
                                r_res_ok <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_count  <= r_count + 1'b1;
                        r_res_ok <= 1'b1;
                        r_state  <= S_PUT;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (w_rdata >= r_val) begin
                        r_idx   <= w_idx_m1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count  <= r_count + 1'b1;
                        r_res_ok <= 1'b1;
                        r_state  <= S_PUT;
                    end
                end
                S_REM_RD: begin
                    if (w_idx_p1 >= r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_REM_WR;
                    end
                end
                S_REM_WR: begin
                    r_idx   <= w_idx_p1;
                    r_state <= S_REM_RD;
                end
                S_SRCH_RD: begin
                    r_state <= (r_idx == r_count) ? S_PUT : S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (w_rdata == r_val) begin
                        r_res_found <= w_idx_p1;
                        r_state     <= S_PUT;
                    end else begin
                        r_idx   <= w_idx_p1;
                        r_state <= S_SRCH_RD;
                    end
                end
                S_PUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid  <= 1'b1;
                        r_ok      <= r_res_ok;
                        r_found   <= 7'(r_res_found);
                        r_cnt_out <= 7'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_ok             = r_ok;
    assign o_found_position = r_found;
    assign o_count          = r_cnt_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sle_pkg::CNT_W'(sle_pkg::CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Sequencer did not leave idle after taking a word.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_req.we |-> (r_idx < sle_pkg::CNT_W'(sle_pkg::CAPACITY)))
        else $error("Memory write beyond capacity.");

endmodule

/* rtl/core/sle_ram.sv */
module sle_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* tb/sorted_list_engine_unit_tb.sv */
module sorted_list_engine_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       ok;
        logic [6:0] found;
        logic [6:0] count;
    } t_outcome;

    class list_scoreboard;
        sle_pkg::t_val list_vals[$];
        t_outcome      pending[$];
        int            errors;

        function void note_command(logic [2:0] cmd, logic [31:0] val, logic [6:0] pos);
            t_outcome      r;
            sle_pkg::t_val v;
            int            at;
            v = sle_pkg::t_val'(val);
            r.ok = 1'b0;
            r.found = '0;
            case (cmd)
                sle_pkg::CMD_INSERT: begin
                    if (list_vals.size() < sle_pkg::CAPACITY) begin
                        at = 0;
                        while (at < list_vals.size() && list_vals[at] < v) at++;
                        list_vals.insert(at, v);
                        r.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_REM_FIRST: begin
                    if (list_vals.size() > 0) begin
                        void'(list_vals.pop_front());
                        r.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_REM_LAST: begin
                    if (list_vals.size() > 0) begin
                        void'(list_vals.pop_back());
                        r.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_REM_AT: begin
                    if (pos >= 1 && pos <= list_vals.size()) begin
                        list_vals.delete(pos - 1);
                        r.ok = 1'b1;
                    end
                end
                sle_pkg::CMD_SEARCH: begin
                    for (int i = 0; i < list_vals.size(); i++) begin
                        if (list_vals[i] == v) begin
                            r.found = 7'(i + 1);
                            break;
                        end
                    end
                    r.ok = 1'b1;
                end
                sle_pkg::CMD_CLEAR: begin
                    list_vals.delete();
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            r.count = 7'(list_vals.size());
            pending.push_back(r);
        endfunction

        function void check_result(logic ok, logic [6:0] found, logic [6:0] count);
            t_outcome e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ok=%0d found=%0d count=%0d",
                         $time, ok, found, count);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: ok expected %0d actual %0d", $time, e.ok, ok);
                errors++;
            end
            if (found !== e.found) begin
                $display("%0t: found_position expected %0d actual %0d", $time, e.found, found);
                errors++;
            end
            if (count !== e.count) begin
                $display("%0t: count expected %0d actual %0d", $time, e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = '0;
    logic [31:0] i_value = '0;
    logic [6:0]  i_position = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_ok;
    logic [6:0]  o_found_position;
    logic [6:0]  o_count;

    list_scoreboard sb;
    bit             quiet_phase = 0;
    longint         cycle_cnt = 0;

    sorted_list_engine_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 3000000) begin
            $display("sorted_list_engine_unit_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_ok, o_found_position, o_count);
    end

    initial begin : stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic [2:0] cmd, logic [31:0] val, logic [6:0] pos);
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(cmd, val, pos);
    endtask

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    initial begin : main
        logic [2:0]  cmd;
        logic [31:0] val;
        int          sel;
        int          fill;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(sle_pkg::CMD_REM_FIRST, '0, 7'd0);
        send_word(sle_pkg::CMD_REM_LAST, '0, 7'd0);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd1);
        send_word(sle_pkg::CMD_SEARCH, 32'd5, 7'd0);
        send_word(sle_pkg::CMD_INSERT, 32'h7fff_ffff, 7'd0);
        send_word(sle_pkg::CMD_INSERT, 32'h8000_0000, 7'd0);
        send_word(sle_pkg::CMD_INSERT, 32'd0, 7'd0);
        send_word(sle_pkg::CMD_INSERT, 32'd0, 7'd0);
        send_word(sle_pkg::CMD_SEARCH, 32'd0, 7'd0);
        send_word(sle_pkg::CMD_SEARCH, 32'h8000_0000, 7'd0);
        send_word(sle_pkg::CMD_SEARCH, 32'h7fff_ffff, 7'd0);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd0);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd127);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd5);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd2);
        send_word(3'd6, 32'hffff_ffff, 7'h7f);
        send_word(3'd7, 32'd1, 7'd1);
        send_word(sle_pkg::CMD_REM_FIRST, '0, 7'd0);
        send_word(sle_pkg::CMD_REM_LAST, '0, 7'd0);
        send_word(sle_pkg::CMD_CLEAR, '0, 7'd0);
        for (int i = 0; i < 65; i++)
            send_word(sle_pkg::CMD_INSERT, $urandom, 7'd0);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd64);
        send_word(sle_pkg::CMD_REM_AT, '0, 7'd65);
        send_word(sle_pkg::CMD_CLEAR, '0, 7'd0);

        for (int i = 0; i < 1850; i++) begin
            if (i > 1600) quiet_phase = 1;
            sel = $urandom_range(0, 99);
            fill = sb.list_vals.size();
            val = pick_value($urandom_range(0, 9) < 5 ? 2 : $urandom_range(0, 3));
            if (sel < 40 - fill / 3)      cmd = sle_pkg::CMD_INSERT;
            else if (sel < 50)            cmd = sle_pkg::CMD_REM_FIRST;
            else if (sel < 58)            cmd = sle_pkg::CMD_REM_LAST;
            else if (sel < 70)            cmd = sle_pkg::CMD_REM_AT;
            else if (sel < 93)            cmd = sle_pkg::CMD_SEARCH;
            else if (sel < 95)            cmd = sle_pkg::CMD_CLEAR;
            else if (sel < 97)            cmd = 3'($urandom_range(6, 7));
            else                          cmd = sle_pkg::CMD_INSERT;
            if (cmd == sle_pkg::CMD_SEARCH && fill > 0 && $urandom_range(0, 1))
                val = sb.list_vals[$urandom_range(0, fill - 1)];
            send_word(cmd, val,
                      $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, fill + 1)));
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sorted_list_engine_unit_tb passed");
        else
            $display("sorted_list_engine_unit_tb failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/sle_pkg.sv
rtl/core/sle_ram.sv
rtl/core/sorted_list_engine_unit.sv
tb/sorted_list_engine_unit_tb.sv
